FILE: rtl/sclt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_pkg
// Shared types and constants of the command line tokenizer: token kinds,
// character codes and the per-byte result record that crosses the queue.
// ----------------------------------------------------------------------------
package sclt_pkg;

	localparam int MaxRes = 3;                 // results one byte can cause
	localparam int QDepth = 4;                 // record queue depth
	localparam int QPtrW  = $clog2(QDepth);

	localparam logic [2:0] KindByte    = 3'd0;
	localparam logic [2:0] KindEndWord = 3'd1;
	localparam logic [2:0] KindPipe    = 3'd2;
	localparam logic [2:0] KindEndCmd  = 3'd3;
	localparam logic [2:0] KindLineOk  = 3'd4;
	localparam logic [2:0] KindLineErr = 3'd5;

	localparam logic [7:0] ChNul     = 8'h00;
	localparam logic [7:0] ChSqOpen  = 8'h01;
	localparam logic [7:0] ChSqClose = 8'h02;
	localparam logic [7:0] ChTab     = 8'h09;
	localparam logic [7:0] ChNl      = 8'h0A;
	localparam logic [7:0] ChVt      = 8'h0B;
	localparam logic [7:0] ChFf      = 8'h0C;
	localparam logic [7:0] ChCr      = 8'h0D;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChDquote  = 8'h22;
	localparam logic [7:0] ChHash    = 8'h23;
	localparam logic [7:0] ChDollar  = 8'h24;
	localparam logic [7:0] ChSquote  = 8'h27;
	localparam logic [7:0] ChSemi    = 8'h3B;
	localparam logic [7:0] ChBslash  = 8'h5C;
	localparam logic [7:0] ChBtick   = 8'h60;
	localparam logic [7:0] ChPipe    = 8'h7C;

	// results caused by one input byte, slot 0 first
	typedef struct packed {
		logic [1:0]                  count;
		logic [MaxRes-1:0][2:0]      kind;
		logic [MaxRes-1:0][7:0]      chr;
	} rec_t;

endpackage

FILE: rtl/sclt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_front
// Takes one byte per cycle while the queue has room, updates the quoting and
// word state and builds each byte's result record. Empty records are not queued.
// ----------------------------------------------------------------------------
module sclt_front import sclt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] char_in,
	input  logic       q_ready,
	output logic       q_push,
	output rec_t       q_rec
);

	typedef struct packed {
		logic sq;
		logic dq;
		logic esc;
		logic dqb;
		logic cmt;
		logic wb;
		logic cw;
	} tok_state_t;

	tok_state_t st_q;
	tok_state_t nx;
	rec_t       rec;
	logic [1:0] cnt;
	logic       done;
	logic       quoted;
	logic       accept;

	assign item_ready = q_ready;
	assign accept     = item_valid && item_ready;

	always_comb begin
		nx     = st_q;
		rec    = '0;
		cnt    = 2'd0;
		done   = 1'b0;
		quoted = 1'b0;
		if (char_in == ChNul) begin
			if (st_q.sq || st_q.dq || st_q.esc || st_q.dqb) begin
				rec.kind[cnt] = KindLineErr;
				cnt = cnt + 2'd1;
			end else begin
				if (st_q.wb) begin
					rec.kind[cnt] = KindEndWord;
					cnt = cnt + 2'd1;
				end
				if (st_q.wb || st_q.cw) begin
					rec.kind[cnt] = KindEndCmd;
					cnt = cnt + 2'd1;
				end
				rec.kind[cnt] = KindLineOk;
				cnt = cnt + 2'd1;
			end
			nx = '0;
		end else begin
			if (nx.cmt) begin
				if (char_in != ChNl)
					done = 1'b1;
				else
					nx.cmt = 1'b0;
			end
			if (!done && nx.esc) begin
				nx.esc = 1'b0;
				rec.kind[cnt] = KindByte;
				rec.chr[cnt]  = char_in;
				cnt = cnt + 2'd1;
				nx.wb = 1'b1;
				done = 1'b1;
			end
			if (!done && nx.dqb) begin
				nx.dqb = 1'b0;
				rec.kind[cnt] = KindByte;
				nx.wb = 1'b1;
				if (char_in == ChDollar || char_in == ChBtick || char_in == ChDquote ||
				    char_in == ChBslash || char_in == ChNl) begin
					rec.chr[cnt] = char_in;
					done = 1'b1;
				end else begin
					rec.chr[cnt] = ChBslash;
				end
				cnt = cnt + 2'd1;
			end
			quoted = nx.sq || nx.dq;
			if (!done) begin
				priority if (char_in == ChBslash && !nx.sq) begin
					if (nx.dq)
						nx.dqb = 1'b1;
					else
						nx.esc = 1'b1;
				end else if (char_in == ChSquote && !nx.dq) begin
					rec.kind[cnt] = KindByte;
					rec.chr[cnt]  = nx.sq ? ChSqClose : ChSqOpen;
					cnt = cnt + 2'd1;
					nx.wb = 1'b1;
					nx.sq = !nx.sq;
				end else if (char_in == ChDquote && !nx.sq) begin
					nx.dq = !nx.dq;
				end else if (!quoted && char_in == ChHash) begin
					nx.cmt = 1'b1;
				end else if (!quoted && (char_in == ChNl || char_in == ChSemi)) begin
					if (nx.wb) begin
						rec.kind[cnt] = KindEndWord;
						cnt = cnt + 2'd1;
					end
					if (nx.wb || nx.cw) begin
						rec.kind[cnt] = KindEndCmd;
						cnt = cnt + 2'd1;
					end
					nx.wb = 1'b0;
					nx.cw = 1'b0;
				end else if (!quoted && (char_in == ChSpace || char_in == ChTab ||
				             char_in == ChVt || char_in == ChFf || char_in == ChCr)) begin
					if (nx.wb) begin
						rec.kind[cnt] = KindEndWord;
						cnt = cnt + 2'd1;
						nx.cw = 1'b1;
					end
					nx.wb = 1'b0;
				end else if (!quoted && char_in == ChPipe) begin
					if (nx.wb) begin
						rec.kind[cnt] = KindEndWord;
						cnt = cnt + 2'd1;
					end
					rec.kind[cnt] = KindPipe;
					cnt = cnt + 2'd1;
					nx.wb = 1'b0;
					nx.cw = 1'b1;
				end else begin
					rec.kind[cnt] = KindByte;
					rec.chr[cnt]  = char_in;
					cnt = cnt + 2'd1;
					nx.wb = 1'b1;
				end
			end
		end
		rec.count = cnt;
	end

	assign q_push = accept && (rec.count != 2'd0);
	assign q_rec  = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= nx;
		end
	end

endmodule

FILE: rtl/sclt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_queue
// Short record queue between the front and back parts.
// ----------------------------------------------------------------------------
module sclt_queue import sclt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic push_ready,
	input  logic pop,
	output rec_t head,
	output logic head_valid
);

	rec_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign head_valid = (count_q != '0);
	assign push_ready = (count_q != (QPtrW+1)'(QDepth));
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QPtrW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QPtrW+1)'(1);
		end
	end

endmodule

FILE: rtl/sclt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_back
// Unrolls queued records through an output register, one token per cycle while token_ready is high.
// ----------------------------------------------------------------------------
module sclt_back import sclt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rec_t       head,
	input  logic       head_valid,
	output logic       pop,
	output logic       token_valid,
	input  logic       token_ready,
	output logic [2:0] token_kind,
	output logic [7:0] char_out,
	output logic       last_of_run
);

	rec_t       cur_q;
	logic [1:0] idx_q;
	logic       cur_v_q;
	logic       valid_q;
	logic [2:0] kind_q;
	logic [7:0] chr_q;
	logic       last_q;
	logic       load;
	logic [1:0] idx_nx;

	assign load   = !valid_q || token_ready;
	assign pop    = load && !cur_v_q && head_valid;
	assign idx_nx = 2'(idx_q + 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cur_v_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			if (cur_v_q) begin
				valid_q <= 1'b1;
				if (idx_nx == cur_q.count)
					cur_v_q <= 1'b0;
				idx_q <= idx_nx;
			end else if (head_valid) begin
				valid_q <= 1'b1;
				cur_v_q <= (head.count != 2'd1);
				idx_q   <= 2'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (cur_v_q) begin
				kind_q <= cur_q.kind[idx_q];
				chr_q  <= cur_q.chr[idx_q];
				last_q <= (idx_nx == cur_q.count);
			end else if (head_valid) begin
				cur_q  <= head;
				kind_q <= head.kind[0];
				chr_q  <= head.chr[0];
				last_q <= (head.count == 2'd1);
			end
		end
	end

	assign token_valid = valid_q;
	assign token_kind  = kind_q;
	assign char_out    = chr_q;
	assign last_of_run = last_q;

`ifndef SYNTHESIS
	// a partly sent record always has its earlier token on the output
	a_cur_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> valid_q && !last_q)
		else $error("record in progress without pending token");

	// the slot index stays inside the record
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> (idx_q < cur_q.count))
		else $error("slot index past record count");

	// no pop while a record is still being sent
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> !pop)
		else $error("queue popped during a record");

	// only word bytes carry a character
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (kind_q != KindByte) |-> (chr_q == ChNul))
		else $error("non-byte token with nonzero character");
`endif

endmodule

FILE: rtl/shell_command_line_tokenizer_top.sv
`timescale 1ns / 1ps
// Path: the first token of a byte is written into the record queue and then loaded into
// the output register before it is valid.
// Throughput: one byte per cycle while the four-record queue has room; one token per
// cycle out of the output register while the receiver is ready.
// Bytes that cause no token take no queue slot and produce no output.
// Reset: asynchronous, clears the tokenizer state, the queue and the output register.
// ----------------------------------------------------------------------------
// shell_command_line_tokenizer_top
// Shell command line word tokenizer: front classifier, record queue and
// token serializer.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer_top import sclt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] char_in,
	output logic       token_valid,
	input  logic       token_ready,
	output logic [2:0] token_kind,
	output logic [7:0] char_out,
	output logic       last_of_run
);

	logic q_push;
	logic q_ready;
	rec_t q_rec;
	rec_t q_head;
	logic q_head_valid;
	logic q_pop;

	sclt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.char_in    (char_in),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_rec      (q_rec)
	);

	sclt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_rec   (q_rec),
		.push_ready (q_ready),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	sclt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.head_valid  (q_head_valid),
		.pop         (q_pop),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_kind  (token_kind),
		.char_out    (char_out),
		.last_of_run (last_of_run)
	);

endmodule

FILE: test/tb_shell_command_line_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_command_line_tokenizer_top
// Feeds command lines byte by byte into the tokenizer and checks every token
// against a behavioral tokenizer held in a small scoreboard. A directed line
// set comes first. Random lines follow, mostly well formed with some broken
// ones and noise. The runs go through phases of sender idling and receiver
// stalls, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_shell_command_line_tokenizer_top;
	import sclt_pkg::*;

	localparam int IdleLimit = 4000;   // cycles with no handshake before giving up
	localparam int HoldCycles = 300;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] chr;
		logic       last;
	} token_t;

	class token_scoreboard;
		token_t tokens_due[$];
		token_t run[$];
		int     errors;
		bit     sq, dq, esc, dq_bs, cmt, word_open, cmd_open;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			sq = 0;
			dq = 0;
			esc = 0;
			dq_bs = 0;
			cmt = 0;
			word_open = 0;
			cmd_open = 0;
		endfunction

		function int pending();
			return tokens_due.size();
		endfunction

		function void put(logic [2:0] k, logic [7:0] c);
			token_t t;
			if (run.size() >= 4)
				return;
			t.kind = k;
			t.chr = c;
			t.last = 1'b0;
			run.push_back(t);
		endfunction

		function void put_byte(logic [7:0] c);
			put(KindByte, c);
			word_open = 1;
		endfunction

		function void close_word();
			if (word_open) begin
				put(KindEndWord, ChNul);
				word_open = 0;
				cmd_open = 1;
			end
		endfunction

		function void close_cmd();
			if (cmd_open) begin
				put(KindEndCmd, ChNul);
				cmd_open = 0;
			end
		endfunction

		function void end_line();
			if (sq || dq || esc || dq_bs) begin
				put(KindLineErr, ChNul);
			end else begin
				close_word();
				close_cmd();
				put(KindLineOk, ChNul);
			end
			clear();
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == ChSpace || c == ChTab || c == ChVt || c == ChFf || c == ChCr;
		endfunction

		function void step(logic [7:0] c);
			if (cmt) begin
				if (c == ChNul) begin
					end_line();
					return;
				end
				if (c != ChNl)
					return;
				cmt = 0;
			end
			if (esc) begin
				if (c == ChNul) begin
					end_line();
					return;
				end
				esc = 0;
				put_byte(c);
				return;
			end
			if (dq_bs) begin
				if (c == ChNul) begin
					end_line();
					return;
				end
				dq_bs = 0;
				if (c == ChDollar || c == ChBtick || c == ChDquote || c == ChBslash ||
				    c == ChNl) begin
					put_byte(c);
					return;
				end
				put_byte(ChBslash);
			end
			if (c == ChNul) begin
				end_line();
				return;
			end
			if (c == ChBslash && !sq) begin
				if (dq)
					dq_bs = 1;
				else
					esc = 1;
				return;
			end
			if (c == ChSquote && !dq) begin
				put_byte(sq ? ChSqClose : ChSqOpen);
				sq = !sq;
				return;
			end
			if (c == ChDquote && !sq) begin
				dq = !dq;
				return;
			end
			if (!sq && !dq) begin
				if (c == ChHash) begin
					cmt = 1;
					return;
				end
				if (c == ChNl || c == ChSemi) begin
					close_word();
					close_cmd();
					return;
				end
				if (is_blank(c)) begin
					close_word();
					return;
				end
				if (c == ChPipe) begin
					close_word();
					put(KindPipe, ChNul);
					cmd_open = 1;
					return;
				end
			end
			put_byte(c);
		endfunction

		function void note_byte(logic [7:0] c);
			run.delete();
			step(c);
			if (run.size() > 0)
				run[run.size()-1].last = 1'b1;
			foreach (run[i])
				tokens_due.push_back(run[i]);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("%0t token error: %s", $realtime, what);
		endtask

		task check_token(logic [2:0] k, logic [7:0] c, logic l);
			token_t e;
			if (tokens_due.size() == 0) begin
				report($sformatf("unexpected token kind %0d char %02h", k, c));
				return;
			end
			e = tokens_due.pop_front();
			if (k !== e.kind)
				report($sformatf("kind %0d, want %0d", k, e.kind));
			if (c !== e.chr)
				report($sformatf("char %02h, want %02h", c, e.chr));
			if (l !== e.last)
				report($sformatf("last_of_run %b, want %b", l, e.last));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic [7:0] char_in = 8'h00;
	logic       token_valid;
	logic       token_ready = 1'b0;
	logic [2:0] token_kind;
	logic [7:0] char_out;
	logic       last_of_run;

	token_scoreboard sb;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	logic [7:0] directed[$] = '{
		8'h61, 8'hFF, ChTab,
		ChDquote, ChBslash, ChDollar, ChBslash, 8'h78, ChDquote, ChVt,
		ChDquote, ChDquote, ChFf,
		ChSquote, ChHash, ChSquote, ChPipe,
		ChSqOpen, ChSqClose, ChHash, 8'h7A, ChNl,
		ChBslash, ChNl, ChCr, ChSemi,
		8'h71, ChSpace, 8'h72, ChNul,
		ChSquote, 8'h6B, ChNul,
		ChBslash, ChNul
	};

	shell_command_line_tokenizer_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.char_in     (char_in),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_kind  (token_kind),
		.char_out    (char_out),
		.last_of_run (last_of_run)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] pick_nz(logic [7:0] ban0, logic [7:0] ban1);
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == ban0 || c == ban1);
		return c;
	endfunction

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 9))
			0: return 8'h80 + 8'($urandom_range(0, 127));
			1: return $urandom_range(0, 1) ? ChSqOpen : ChSqClose;
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 4))
			0: return ChSpace;
			1: return ChTab;
			2: return ChVt;
			3: return ChFf;
			default: return ChCr;
		endcase
	endfunction

	// byte after a backslash inside double quotes: mostly one that it escapes
	function automatic logic [7:0] dq_follow();
		case ($urandom_range(0, 6))
			0: return ChDollar;
			1: return ChBtick;
			2: return ChDquote;
			3: return ChBslash;
			4: return ChNl;
			default: return pick_nz(ChNul, ChNul);
		endcase
	endfunction

	function automatic void gen_line(ref logic [7:0] q[$]);
		int parts;
		q.delete();
		if ($urandom_range(0, 99) < 10) begin
			repeat ($urandom_range(1, 12))
				q.push_back(pick_nz(ChNul, ChNul));
			q.push_back(ChNul);
			return;
		end
		parts = $urandom_range(1, 7);
		repeat (parts) begin
			case ($urandom_range(0, 11))
				3: begin
					q.push_back(ChSquote);
					repeat ($urandom_range(0, 3))
						q.push_back(pick_nz(ChSquote, ChNul));
					q.push_back(ChSquote);
				end
				4: begin
					q.push_back(ChDquote);
					repeat ($urandom_range(0, 3)) begin
						if ($urandom_range(0, 2) == 0) begin
							q.push_back(ChBslash);
							q.push_back(dq_follow());
						end else begin
							q.push_back(pick_nz(ChDquote, ChBslash));
						end
					end
					q.push_back(ChDquote);
				end
				5: begin
					q.push_back(ChBslash);
					q.push_back(pick_nz(ChNul, ChNul));
				end
				6: q.push_back(blank_char());
				7: q.push_back($urandom_range(0, 1) ? ChSemi : ChNl);
				8: q.push_back(ChPipe);
				9: begin
					q.push_back(ChHash);
					repeat ($urandom_range(0, 3))
						q.push_back(pick_nz(ChNl, ChNul));
					if ($urandom_range(0, 2) != 0)
						q.push_back(ChNl);
				end
				default: begin
					repeat ($urandom_range(1, 4))
						q.push_back(word_char());
				end
			endcase
		end
		// broken tail: open quote, trailing escape or pending dq backslash
		if ($urandom_range(0, 99) < 12) begin
			case ($urandom_range(0, 3))
				0: q.push_back(ChSquote);
				1: q.push_back(ChDquote);
				2: q.push_back(ChBslash);
				default: begin
					q.push_back(ChDquote);
					q.push_back(ChBslash);
				end
			endcase
		end
		q.push_back(ChNul);
	endfunction

	task offer_byte(input logic [7:0] c);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		char_in <= c;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_byte(c);
	endtask

	task wait_tokens_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// receiver: random stalls plus an on-request long hold-off
	always @(posedge clk) begin
		if (arst_n && token_valid && token_ready)
			sb.check_token(token_kind, char_out, last_of_run);
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			token_ready <= 1'b0;
		end else begin
			token_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (token_valid && token_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IdleLimit) begin
			$display("shell_command_line_tokenizer_top: mismatch");
			$finish;
		end
	end

	initial begin
		logic [7:0] line[$];
		int sent;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_byte(directed[i]);
		wait_tokens_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 63; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 63; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			sent = 0;
			if (ph == 0) begin
				// long receiver hold-off while a long word keeps coming in
				hold_req <= 1'b1;
				repeat (24)
					offer_byte(word_char());
				offer_byte(ChNul);
				sent = 25;
			end
			while (sent < 111) begin
				gen_line(line);
				foreach (line[i])
					offer_byte(line[i]);
				sent += line.size();
			end
			wait_tokens_drained();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("shell_command_line_tokenizer_top: match");
		else
			$display("shell_command_line_tokenizer_top: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sclt_pkg.sv
rtl/sclt_front.sv
rtl/sclt_queue.sv
rtl/sclt_back.sv
rtl/shell_command_line_tokenizer_top.sv
test/tb_shell_command_line_tokenizer_top.sv
